// ===== rtl/core/rmq_pkg.sv =====
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared constants and types for the matrix-to-quaternion converter.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 30;

  localparam int              THR_W     = 31;
  localparam logic [THR_W-1:0] THR_RESET = 31'd10737;

  // scaled magnitudes stay below 2^FIT_W so four squares fit in SUM_W bits
  localparam int FIT_W  = 31;
  localparam int SUM_W  = 64;
  localparam int ROOT_W = 32;

  localparam int QUEUE_DEPTH = 4;

  // leading component chosen by the front end
  typedef enum logic [1:0] {
    SEL_X     = 2'd0,
    SEL_Y     = 2'd1,
    SEL_Z     = 2'd2,
    SEL_TRACE = 2'd3
  } sel_t;

endpackage

// ===== rtl/core/rmq_front.sv =====
// ----------------------------------------------------------------------------
// rmq_front
// Input stage: takes a matrix, picks the branch and leading axis.
// ----------------------------------------------------------------------------
module rmq_front #(
  parameter int DW = rmq_pkg::DATA_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [9*DW-1:0]          mat,
  input  logic [rmq_pkg::THR_W-1:0] thr,
  output logic                     push,
  input  logic                     q_full,
  output logic [9*DW+1:0]          push_data
);

  localparam int CW = (DW + 2 > rmq_pkg::THR_W + 1) ? DW + 2 : rmq_pkg::THR_W + 1;

  logic             f_valid;
  logic [9*DW-1:0]  f_mat;
  rmq_pkg::sel_t    f_sel;
  rmq_pkg::sel_t    sel_next;
  logic signed [CW-1:0] tr;
  logic signed [DW-1:0] d0, d1, d2;
  logic             accept;

  assign d0 = mat[0*DW +: DW];
  assign d1 = mat[4*DW +: DW];
  assign d2 = mat[8*DW +: DW];
  assign tr = CW'(d0) + CW'(d1) + CW'(d2);

  always_comb begin
    if (tr > $signed({{(CW-rmq_pkg::THR_W){1'b0}}, thr})) begin
      sel_next = rmq_pkg::SEL_TRACE;
    end else if (d2 > d1 && d2 > d0) begin
      sel_next = rmq_pkg::SEL_Z;
    end else if (d1 > d0) begin
      // ties go to the lower axis
      sel_next = (d2 > d1) ? rmq_pkg::SEL_Z : rmq_pkg::SEL_Y;
    end else begin
      sel_next = rmq_pkg::SEL_X;
    end
  end

  assign in_stall  = f_valid && q_full;
  assign accept    = in_valid && !in_stall;
  assign push      = f_valid && !q_full;
  assign push_data = {f_sel, f_mat};

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (push) begin
      f_valid <= 1'b0;
    end
    if (accept) begin
      f_mat <= mat;
      f_sel <= sel_next;
    end
  end

endmodule

// ===== rtl/core/rmq_fifo.sv =====
// ----------------------------------------------------------------------------
// rmq_fifo
// Short request queue between the front and back ends.
// ----------------------------------------------------------------------------
module rmq_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = rmq_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic         empty,
  output logic [W-1:0] dout
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem [0:DEPTH-1];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;

  assign full  = (count == (AW+1)'(DEPTH));
  assign empty = (count == '0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

// ===== rtl/core/rmq_isqrt.sv =====
// ----------------------------------------------------------------------------
// rmq_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module rmq_isqrt #(
  parameter int SIDE_W = 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [rmq_pkg::SUM_W-1:0]  radicand,
  input  logic [SIDE_W-1:0]          side_in,
  output logic                       out_valid,
  output logic [rmq_pkg::ROOT_W-1:0] root,
  output logic [SIDE_W-1:0]          side_out
);

  localparam int RW    = rmq_pkg::ROOT_W;
  localparam int SW    = rmq_pkg::SUM_W;
  localparam int REM_W = RW + 2;

  logic              vld [0:RW-1];
  logic [RW-1:0]     rt  [0:RW-1];
  logic [SIDE_W-1:0] sd  [0:RW-1];
  logic [SW-1:0]     rad [0:RW-2];
  logic [REM_W-1:0]  rem [0:RW-2];

  genvar s;
  for (s = 0; s < RW; s++) begin : g_stage
    logic              p_vld;
    logic [RW-1:0]     p_rt;
    logic [SIDE_W-1:0] p_sd;
    logic [SW-1:0]     p_rad;
    logic [REM_W-1:0]  p_rem;
    logic [REM_W-1:0]  rr;
    logic [REM_W-1:0]  trial;
    logic              fit;

    if (s == 0) begin : g_first
      assign p_vld = in_valid;
      assign p_rt  = '0;
      assign p_sd  = side_in;
      assign p_rad = radicand;
      assign p_rem = '0;
    end else begin : g_next
      assign p_vld = vld[s-1];
      assign p_rt  = rt[s-1];
      assign p_sd  = sd[s-1];
      assign p_rad = rad[s-1];
      assign p_rem = rem[s-1];
    end

    assign rr    = {p_rem[REM_W-3:0], p_rad[2*(RW-1-s)+1 -: 2]};
    assign trial = {p_rt, 2'b01};
    assign fit   = (rr >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= p_vld;
      end
      if (en) begin
        rt[s] <= {p_rt[RW-2:0], fit};
        sd[s] <= p_sd;
      end
    end

    if (s < RW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rad[s] <= p_rad;
          rem[s] <= fit ? rr - trial : rr;
        end
      end
    end
  end

  assign out_valid = vld[RW-1];
  assign root      = rt[RW-1];
  assign side_out  = sd[RW-1];

endmodule

// ===== rtl/core/rmq_div.sv =====
// ----------------------------------------------------------------------------
// rmq_div
// Four-lane pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rmq_div #(
  parameter int FB     = rmq_pkg::FRAC_BITS_DEF,
  parameter int SIDE_W = 1
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    en,
  input  logic                                    in_valid,
  input  logic [3:0][rmq_pkg::FIT_W+FB:0]         num,
  input  logic [rmq_pkg::ROOT_W-1:0]              den,
  input  logic [SIDE_W-1:0]                       side_in,
  output logic                                    out_valid,
  output logic [3:0][FB:0]                        quo,
  output logic [SIDE_W-1:0]                       side_out
);

  localparam int RW = rmq_pkg::ROOT_W;
  localparam int QW = FB + 1;
  localparam int NW = rmq_pkg::FIT_W + FB + 1;

  logic                   vld  [0:QW-1];
  logic [3:0][QW-1:0]     qacc [0:QW-1];
  logic [SIDE_W-1:0]      sd   [0:QW-1];
  logic [3:0][NW-1:0]     nm   [0:QW-2];
  logic [RW-1:0]          dn   [0:QW-2];
  logic [3:0][RW-1:0]     rm   [0:QW-2];

  genvar s;
  for (s = 0; s < QW; s++) begin : g_stage
    logic               p_vld;
    logic [3:0][QW-1:0] p_q;
    logic [SIDE_W-1:0]  p_sd;
    logic [3:0][NW-1:0] p_nm;
    logic [RW-1:0]      p_dn;
    logic [3:0][RW-1:0] p_rm;
    logic [3:0][RW-1:0] n_rm;
    logic [3:0]         ge;

    if (s == 0) begin : g_first
      assign p_vld = in_valid;
      assign p_q   = '0;
      assign p_sd  = side_in;
      assign p_nm  = num;
      assign p_dn  = den;
      always_comb begin
        for (int c = 0; c < 4; c++) begin
          p_rm[c] = RW'(num[c][NW-1:QW]);
        end
      end
    end else begin : g_next
      assign p_vld = vld[s-1];
      assign p_q   = qacc[s-1];
      assign p_sd  = sd[s-1];
      assign p_nm  = nm[s-1];
      assign p_dn  = dn[s-1];
      assign p_rm  = rm[s-1];
    end

    always_comb begin
      logic [RW:0] r2;
      for (int c = 0; c < 4; c++) begin
        r2    = {p_rm[c], p_nm[c][QW-1-s]};
        ge[c] = (r2 >= {1'b0, p_dn});
        n_rm[c] = ge[c] ? RW'(r2 - {1'b0, p_dn}) : RW'(r2);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= p_vld;
      end
      if (en) begin
        for (int c = 0; c < 4; c++) begin
          qacc[s][c] <= {p_q[c][QW-2:0], ge[c]};
        end
        sd[s] <= p_sd;
      end
    end

    if (s < QW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          nm[s] <= p_nm;
          dn[s] <= p_dn;
          rm[s] <= n_rm;
        end
      end
    end
  end

  assign out_valid = vld[QW-1];
  assign quo       = qacc[QW-1];
  assign side_out  = sd[QW-1];

endmodule

// ===== rtl/core/rmq_back.sv =====
// ----------------------------------------------------------------------------
// rmq_back
// Execution pipeline: raw components, scaling, norm, divide, output register.
// ----------------------------------------------------------------------------
module rmq_back #(
  parameter int DW = rmq_pkg::DATA_WIDTH_DEF,
  parameter int FB = rmq_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_empty,
  input  logic [9*DW+1:0]      q_data,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [DW-1:0] q_x,
  output logic signed [DW-1:0] q_y,
  output logic signed [DW-1:0] q_z,
  output logic signed [DW-1:0] q_w,
  output logic                 degenerate
);

  localparam int VW  = DW + 3;
  localparam int MW  = DW + 2;
  localparam int FW  = rmq_pkg::FIT_W;
  localparam int SW  = rmq_pkg::SUM_W;
  localparam int RW  = rmq_pkg::ROOT_W;
  localparam int QW  = FB + 1;
  localparam int NW  = FW + FB + 1;
  localparam int SHW = $clog2(MW);
  localparam int SQ_SIDE = 1 + 4 + 4 * FW;
  localparam logic [VW-1:0] ONE = VW'(1) << FB;

  function automatic logic signed [VW-1:0] ex(input logic [DW-1:0] x);
    return VW'($signed(x));
  endfunction

  logic adv;
  assign adv   = !out_valid || !out_stall;
  assign q_pop = adv && !q_empty;

  // stage 1: raw components from the selected branch
  rmq_pkg::sel_t        sel;
  logic signed [VW-1:0] e [0:8];
  logic signed [VW-1:0] a;
  logic [3:0][VW-1:0]   v_next;
  logic                 degen_next;

  assign sel = rmq_pkg::sel_t'(q_data[9*DW +: 2]);

  always_comb begin
    for (int n = 0; n < 9; n++) begin
      e[n] = ex(q_data[n*DW +: DW]);
    end
  end

  always_comb begin
    a          = '0;
    v_next     = '0;
    degen_next = 1'b0;
    case (sel)
      rmq_pkg::SEL_TRACE: begin
        v_next[3] = e[0] + e[4] + e[8] + $signed(ONE);
        v_next[0] = e[7] - e[5];
        v_next[1] = e[2] - e[6];
        v_next[2] = e[3] - e[1];
      end
      rmq_pkg::SEL_X: begin
        a         = e[0] - (e[4] + e[8]) + $signed(ONE);
        v_next[0] = a;
        v_next[1] = e[3] + e[1];
        v_next[2] = e[6] + e[2];
        v_next[3] = e[7] - e[5];
        degen_next = a[VW-1] || (a == '0);
      end
      rmq_pkg::SEL_Y: begin
        a         = e[4] - (e[8] + e[0]) + $signed(ONE);
        v_next[1] = a;
        v_next[2] = e[7] + e[5];
        v_next[0] = e[1] + e[3];
        v_next[3] = e[2] - e[6];
        degen_next = a[VW-1] || (a == '0);
      end
      rmq_pkg::SEL_Z: begin
        a         = e[8] - (e[0] + e[4]) + $signed(ONE);
        v_next[2] = a;
        v_next[0] = e[2] + e[6];
        v_next[1] = e[5] + e[7];
        v_next[3] = e[3] - e[1];
        degen_next = a[VW-1] || (a == '0);
      end
      default: begin
        v_next = '0;
      end
    endcase
  end

  logic               s1_valid, s1_degen;
  logic [3:0][VW-1:0] s1_v;

  // stage 2: sign and magnitude
  logic               s2_valid, s2_degen;
  logic [3:0]         s2_neg;
  logic [3:0][MW-1:0] s2_mag;

  // stage 3: scale all magnitudes below 2^FW
  logic               s3_valid, s3_degen;
  logic [3:0]         s3_neg;
  logic [3:0][FW-1:0] s3_mag;
  logic [MW-1:0]      mag_or;
  logic [SHW-1:0]     sh;

  always_comb begin
    mag_or = s2_mag[0] | s2_mag[1] | s2_mag[2] | s2_mag[3];
    sh     = '0;
    for (int b = FW; b < MW; b++) begin
      if (mag_or[b]) begin
        sh = SHW'(b - FW + 1);
      end
    end
  end

  // stage 4: squares
  logic                 s4_valid, s4_degen;
  logic [3:0]           s4_neg;
  logic [3:0][FW-1:0]   s4_mag;
  logic [3:0][2*FW-1:0] s4_sq;

  // stage 5: sum of squares
  logic               s5_valid, s5_degen;
  logic [3:0]         s5_neg;
  logic [3:0][FW-1:0] s5_mag;
  logic [SW-1:0]      s5_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= !q_empty;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
    end
    if (adv) begin
      s1_v     <= v_next;
      s1_degen <= degen_next;

      for (int c = 0; c < 4; c++) begin
        s2_neg[c] <= s1_v[c][VW-1];
        s2_mag[c] <= s1_v[c][VW-1] ? MW'(-s1_v[c]) : MW'(s1_v[c]);
      end
      s2_degen <= s1_degen;

      for (int c = 0; c < 4; c++) begin
        s3_mag[c] <= FW'(s2_mag[c] >> sh);
      end
      s3_neg   <= s2_neg;
      s3_degen <= s2_degen;

      for (int c = 0; c < 4; c++) begin
        s4_sq[c] <= s3_mag[c] * s3_mag[c];
      end
      s4_mag   <= s3_mag;
      s4_neg   <= s3_neg;
      s4_degen <= s3_degen;

      s5_sum   <= (SW'(s4_sq[0]) + SW'(s4_sq[1])) + (SW'(s4_sq[2]) + SW'(s4_sq[3]));
      s5_mag   <= s4_mag;
      s5_neg   <= s4_neg;
      s5_degen <= s4_degen;
    end
  end

  // norm
  logic               sq_valid;
  logic [RW-1:0]      sq_root;
  logic [SQ_SIDE-1:0] sq_side;
  logic               sq_degen;
  logic [3:0]         sq_neg;
  logic [3:0][FW-1:0] sq_mag;

  rmq_isqrt #(
    .SIDE_W(SQ_SIDE)
  ) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (s5_valid),
    .radicand (s5_sum),
    .side_in  ({s5_degen, s5_neg, s5_mag}),
    .out_valid(sq_valid),
    .root     (sq_root),
    .side_out (sq_side)
  );

  assign {sq_degen, sq_neg, sq_mag} = sq_side;

  // rounded quotients |c| * 2^FB / norm
  logic [RW-1:0]      norm;
  logic [3:0][NW-1:0] num;

  always_comb begin
    norm = (sq_root == '0) ? RW'(1) : sq_root;
    for (int c = 0; c < 4; c++) begin
      num[c] = {1'b0, sq_mag[c], {FB{1'b0}}} + NW'(norm >> 1);
    end
  end

  logic               dv_valid;
  logic [3:0][QW-1:0] dv_quo;
  logic               dv_degen;
  logic [3:0]         dv_neg;

  rmq_div #(
    .FB    (FB),
    .SIDE_W(5)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (sq_valid),
    .num      (num),
    .den      (norm),
    .side_in  ({sq_degen, sq_neg}),
    .out_valid(dv_valid),
    .quo      (dv_quo),
    .side_out ({dv_degen, dv_neg})
  );

  logic [3:0][DW-1:0] res;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      if (dv_degen) begin
        res[c] = '0;
      end else if (dv_neg[c]) begin
        res[c] = -DW'(dv_quo[c]);
      end else begin
        res[c] = DW'(dv_quo[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv_valid;
    end
    if (adv) begin
      q_x        <= res[0];
      q_y        <= res[1];
      q_z        <= res[2];
      q_w        <= res[3];
      degenerate <= dv_degen;
    end
  end

endmodule

// ===== rtl/core/rotation_matrix_to_quaternion.sv =====
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Rotation matrix to unit quaternion converter (Shepperd's method).
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall carries one 3x3 matrix (e00..e22, signed
// Q2.FRAC_BITS); output channel out_valid/out_stall returns q_x, q_y, q_z, q_w
// and the degenerate flag. A request moves when valid is high and stall low.
// cfg_valid/cfg_ready writes trace_threshold; cfg_ready is always high and
// writes are expected only while the block is empty.
// Throughput: one matrix per cycle while out_stall is low. A matrix passes a
// front register, the request queue, five arithmetic stages, a 32-stage
// square root, a FRAC_BITS+1 stage divider and the output register on its
// way to out_valid.
// When the receiver stalls, the back pipeline holds and the request queue
// fills; in_stall rises once the queue and the front register are full.
// Reset empties the pipeline and loads the threshold default (about 1e-5).
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion #(
  parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [rmq_pkg::THR_W-1:0]    cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [DATA_WIDTH-1:0] e00,
  input  logic signed [DATA_WIDTH-1:0] e01,
  input  logic signed [DATA_WIDTH-1:0] e02,
  input  logic signed [DATA_WIDTH-1:0] e10,
  input  logic signed [DATA_WIDTH-1:0] e11,
  input  logic signed [DATA_WIDTH-1:0] e12,
  input  logic signed [DATA_WIDTH-1:0] e20,
  input  logic signed [DATA_WIDTH-1:0] e21,
  input  logic signed [DATA_WIDTH-1:0] e22,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0] q_x,
  output logic signed [DATA_WIDTH-1:0] q_y,
  output logic signed [DATA_WIDTH-1:0] q_z,
  output logic signed [DATA_WIDTH-1:0] q_w,
  output logic                         degenerate
);

  localparam int PW = 9 * DATA_WIDTH + 2;

  logic [rmq_pkg::THR_W-1:0] trace_threshold;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      trace_threshold <= rmq_pkg::THR_RESET;
    end else if (cfg_valid) begin
      trace_threshold <= cfg_data;
    end
  end

  logic [9*DATA_WIDTH-1:0] mat;
  logic                    push, q_full, q_pop, q_empty;
  logic [PW-1:0]           push_data, q_data;

  assign mat = {e22, e21, e20, e12, e11, e10, e02, e01, e00};

  rmq_front #(
    .DW(DATA_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .mat      (mat),
    .thr      (trace_threshold),
    .push     (push),
    .q_full   (q_full),
    .push_data(push_data)
  );

  rmq_fifo #(
    .W    (PW),
    .DEPTH(rmq_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (push_data),
    .full (q_full),
    .pop  (q_pop),
    .empty(q_empty),
    .dout (q_data)
  );

  rmq_back #(
    .DW(DATA_WIDTH),
    .FB(FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .q_x       (q_x),
    .q_y       (q_y),
    .q_z       (q_z),
    .q_w       (q_w),
    .degenerate(degenerate)
  );

endmodule
